### hw/rtl/qoi_pkg.sv
// Shared constants, chunk descriptor type and hash function of the QOI encoder.
`timescale 1ns / 1ps

package qoi_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int SLOT_W      = $clog2(TABLE_DEPTH);
	localparam int PIXEL_W     = 32;
	localparam int CHUNK_MAX   = 5;
	localparam int CHUNK_IDX_W = $clog2(CHUNK_MAX + 1);
	localparam int END_LEN     = 8;
	localparam int END_IDX_W   = $clog2(END_LEN);

	localparam logic [7:0] OP_DIFF  = 8'h40;
	localparam logic [7:0] OP_LUMA  = 8'h80;
	localparam logic [7:0] OP_RUN   = 8'hC0;
	localparam logic [7:0] OP_RGB   = 8'hFE;
	localparam logic [7:0] OP_RGBA  = 8'hFF;

	localparam logic [5:0] RUN_MAX      = 6'd62;
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [PIXEL_W-1:0] PREV_RESET = 32'h0000_00FF;
	localparam logic [2:0] CC_RGB = 3'd3;
	localparam logic [2:0] CC_RGBA = 3'd4;
	localparam logic [END_IDX_W-1:0] END_MARK_IDX = END_IDX_W'(END_LEN - 1);
	localparam logic [7:0] END_MARK_BYTE = 8'h01;

	typedef struct packed {
		logic                           run_valid;
		logic [7:0]                     run_byte;
		logic [CHUNK_MAX-1:0][7:0]      bytes;
		logic [CHUNK_IDX_W-1:0]         len;
		logic                           end_valid;
	} chunk_t;

	// Only the low six bits of the weighted sum matter.
	function automatic logic [SLOT_W-1:0] qoi_hash(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [7:0] a);
		logic [SLOT_W-1:0] sum;
		sum = SLOT_W'(r) * SLOT_W'(3) + SLOT_W'(g) * SLOT_W'(5)
			+ SLOT_W'(b) * SLOT_W'(7) + SLOT_W'(a) * SLOT_W'(11);
		return sum;
	endfunction

endpackage

### hw/rtl/qoi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module qoi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/qoi_ser.sv
// Byte serializer: plays out the run byte, the chunk bytes and the end marker of one pixel.
`timescale 1ns / 1ps

module qoi_ser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  qoi_pkg::chunk_t desc,
	output logic            load_ok,
	output logic            byte_valid,
	input  logic            byte_ready,
	output logic [7:0]      out_byte,
	output logic            last_of_pixel,
	output logic            end_of_image
);

	import qoi_pkg::*;

	logic                       run_pend_q;
	logic [7:0]                 run_byte_q;
	logic [CHUNK_MAX-1:0][7:0]  chunk_q;
	logic [CHUNK_IDX_W-1:0]     chunk_len_q;
	logic [CHUNK_IDX_W-1:0]     chunk_idx_q;
	logic                       end_pend_q;
	logic [END_IDX_W-1:0]       end_idx_q;

	logic in_chunk;
	logic chunk_final;
	logic take;

	assign in_chunk    = chunk_idx_q != chunk_len_q;
	assign chunk_final = (chunk_idx_q + CHUNK_IDX_W'(1)) == chunk_len_q;
	assign byte_valid  = run_pend_q || in_chunk || end_pend_q;
	assign take        = byte_valid && byte_ready;

	always_comb begin
		out_byte      = 8'h00;
		last_of_pixel = 1'b0;
		end_of_image  = 1'b0;
		if (run_pend_q) begin
			out_byte      = run_byte_q;
			last_of_pixel = !in_chunk && !end_pend_q;
		end else if (in_chunk) begin
			out_byte      = chunk_q[chunk_idx_q];
			last_of_pixel = chunk_final && !end_pend_q;
		end else if (end_pend_q) begin
			out_byte      = (end_idx_q == END_MARK_IDX) ? END_MARK_BYTE : 8'h00;
			last_of_pixel = end_idx_q == END_MARK_IDX;
			end_of_image  = end_idx_q == END_MARK_IDX;
		end
	end

	// A new descriptor may come in as the final beat of the previous one leaves.
	assign load_ok = !byte_valid || (take && last_of_pixel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_pend_q  <= 1'b0;
			chunk_len_q <= '0;
			chunk_idx_q <= '0;
			end_pend_q  <= 1'b0;
			end_idx_q   <= '0;
		end else if (load) begin
			run_pend_q  <= desc.run_valid;
			chunk_len_q <= desc.len;
			chunk_idx_q <= '0;
			end_pend_q  <= desc.end_valid;
			end_idx_q   <= '0;
		end else if (take) begin
			if (run_pend_q) begin
				run_pend_q <= 1'b0;
			end else if (in_chunk) begin
				chunk_idx_q <= chunk_idx_q + CHUNK_IDX_W'(1);
			end else if (end_idx_q == END_MARK_IDX) begin
				end_pend_q <= 1'b0;
			end else begin
				end_idx_q <= end_idx_q + END_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_byte_q <= desc.run_byte;
			chunk_q    <= desc.bytes;
		end
	end

`ifndef SYNTHESIS
	a_eoi_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && end_of_image |-> last_of_pixel)
		else $error("end marker beat not flagged as last of pixel");
	a_load_safe: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !byte_valid || (byte_ready && last_of_pixel))
		else $error("descriptor loaded over pending beats");
	a_idx_in_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_idx_q <= chunk_len_q)
		else $error("chunk index ran past the chunk length");
`endif

endmodule

### hw/rtl/qoi_image_encoder.sv
// Top level of the QOI chunk encoder: colour table pipeline, pixel state and serializer.
`timescale 1ns / 1ps

// Takes one RGBA pixel per beat and produces the QOI chunk stream (no file header) one byte
// per beat. Each pixel's entry in the 64-entry colour table is read from a synchronous RAM
// at acceptance and compared in the next cycle, where the table is written back, with a
// forwarding register covering a write and a read of the same entry in adjacent pixels.
// Pixels that extend a run or produce a single byte sustain one pixel per cycle while the byte
// output is ready. A pixel that produces more bytes (two for LUMA, four for RGB, five for RGBA,
// one more when a run is flushed ahead of the chunk, eight more for the end marker on the last
// pixel) holds the byte serializer until its last byte is taken, and the input pauses meanwhile.
// After the last pixel the table, previous pixel and run count return to their reset values at
// once (per-entry valid flags), so no clearing pass is needed and the next image may follow
// immediately. channel_count (3 or 4) must be written on cfg_we while idle; nothing enforces it.
module qoi_image_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_wdata,
	input  logic       pix_valid,
	output logic       pix_ready,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic [7:0] alpha,
	input  logic       last_pixel,
	output logic       byte_valid,
	input  logic       byte_ready,
	output logic [7:0] out_byte,
	output logic       last_of_pixel,
	output logic       end_of_image
);

	import qoi_pkg::*;

	logic [2:0]             cc_q;
	logic                   pix_accept;
	logic [7:0]             alpha_in;
	logic [SLOT_W-1:0]      hash_in;

	logic                   s1_valid;
	logic [PIXEL_W-1:0]     px_s1;
	logic [SLOT_W-1:0]      slot_s1;
	logic                   last_s1;

	logic [PIXEL_W-1:0]     prev_q;
	logic [5:0]             run_q;
	logic [TABLE_DEPTH-1:0] tbl_valid_q;
	logic                   fwd_valid_q;
	logic [SLOT_W-1:0]      fwd_slot_q;
	logic [PIXEL_W-1:0]     fwd_data_q;

	logic [PIXEL_W-1:0]     ram_rdata;
	logic [PIXEL_W-1:0]     entry;
	logic                   same;
	logic                   hit;
	logic [5:0]             run_inc;
	logic [5:0]             run_next;
	logic                   tbl_we;
	logic                   emit;
	logic                   s1_adv;
	logic                   ser_load;
	logic                   ser_ok;
	chunk_t                 desc;

	logic [7:0] r_s1, g_s1, b_s1, a_s1;
	logic [7:0] dr, dg, db, rg, bg;
	logic [7:0] dr2, dg2, db2, dg32, rg8, bg8;

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= CC_RGBA;
		end else if (cfg_we) begin
			cc_q <= cfg_wdata;
		end
	end

	assign alpha_in   = (cc_q == CC_RGB) ? ALPHA_OPAQUE : alpha;
	assign hash_in    = qoi_hash(red, green, blue, alpha_in);
	assign pix_ready  = !s1_valid || s1_adv;
	assign pix_accept = pix_valid && pix_ready;

	// Stage 1 holds the pixel while its table entry is read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (pix_ready) begin
			s1_valid <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_accept) begin
			px_s1   <= {red, green, blue, alpha_in};
			slot_s1 <= hash_in;
			last_s1 <= last_pixel;
		end
	end

	qoi_ram #(
		.WIDTH(PIXEL_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (s1_adv && tbl_we),
		.waddr(slot_s1),
		.wdata(px_s1),
		.re   (pix_accept),
		.raddr(hash_in),
		.rdata(ram_rdata)
	);

	assign {r_s1, g_s1, b_s1, a_s1} = px_s1;

	// The RAM read is read-first, so a write in the read cycle is taken from the forward register.
	always_comb begin
		if (!tbl_valid_q[slot_s1]) begin
			entry = '0;
		end else if (fwd_valid_q && fwd_slot_q == slot_s1) begin
			entry = fwd_data_q;
		end else begin
			entry = ram_rdata;
		end
	end

	assign same    = px_s1 == prev_q;
	assign hit     = entry == px_s1;
	assign run_inc = run_q + 6'd1;

	assign dr   = r_s1 - prev_q[31:24];
	assign dg   = g_s1 - prev_q[23:16];
	assign db   = b_s1 - prev_q[15:8];
	assign rg   = dr - dg;
	assign bg   = db - dg;
	assign dr2  = dr + 8'd2;
	assign dg2  = dg + 8'd2;
	assign db2  = db + 8'd2;
	assign dg32 = dg + 8'd32;
	assign rg8  = rg + 8'd8;
	assign bg8  = bg + 8'd8;

	always_comb begin
		desc     = '0;
		run_next = run_q;
		tbl_we   = 1'b0;
		if (same) begin
			if (run_inc >= RUN_MAX || last_s1) begin
				desc.run_valid = 1'b1;
				desc.run_byte  = OP_RUN | {2'b00, run_q};
				run_next       = '0;
			end else begin
				run_next = run_inc;
			end
		end else begin
			run_next = '0;
			if (run_q != 6'd0) begin
				desc.run_valid = 1'b1;
				desc.run_byte  = OP_RUN | {2'b00, run_q - 6'd1};
			end
			if (hit) begin
				desc.bytes[0] = {2'b00, slot_s1};
				desc.len      = CHUNK_IDX_W'(1);
			end else begin
				tbl_we = 1'b1;
				if (a_s1 == prev_q[7:0]) begin
					if (dr2 < 8'd4 && dg2 < 8'd4 && db2 < 8'd4) begin
						desc.bytes[0] = OP_DIFF | {2'b00, dr2[1:0], dg2[1:0], db2[1:0]};
						desc.len      = CHUNK_IDX_W'(1);
					end else if (dg32 < 8'd64 && rg8 < 8'd16 && bg8 < 8'd16) begin
						desc.bytes[0] = OP_LUMA | {2'b00, dg32[5:0]};
						desc.bytes[1] = {rg8[3:0], bg8[3:0]};
						desc.len      = CHUNK_IDX_W'(2);
					end else begin
						desc.bytes[0] = OP_RGB;
						desc.bytes[1] = r_s1;
						desc.bytes[2] = g_s1;
						desc.bytes[3] = b_s1;
						desc.len      = CHUNK_IDX_W'(4);
					end
				end else begin
					desc.bytes[0] = OP_RGBA;
					desc.bytes[1] = r_s1;
					desc.bytes[2] = g_s1;
					desc.bytes[3] = b_s1;
					desc.bytes[4] = a_s1;
					desc.len      = CHUNK_IDX_W'(5);
				end
			end
		end
		desc.end_valid = last_s1;
	end

	assign emit     = desc.run_valid || desc.len != '0 || desc.end_valid;
	assign s1_adv   = s1_valid && (!emit || ser_ok);
	assign ser_load = s1_adv && emit;

	// Pixel state; the last pixel of an image puts everything back to its reset value.
	// The forward mark stays with the pixel that read behind the write until that pixel leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= PREV_RESET;
			run_q       <= '0;
			tbl_valid_q <= '0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (s1_adv) begin
				fwd_valid_q <= tbl_we && !last_s1 && pix_accept;
				if (last_s1) begin
					prev_q      <= PREV_RESET;
					run_q       <= '0;
					tbl_valid_q <= '0;
				end else begin
					prev_q <= px_s1;
					run_q  <= run_next;
					if (tbl_we) begin
						tbl_valid_q[slot_s1] <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			fwd_slot_q <= slot_s1;
			fwd_data_q <= px_s1;
		end
	end

	qoi_ser u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (ser_load),
		.desc         (desc),
		.load_ok      (ser_ok),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.out_byte     (out_byte),
		.last_of_pixel(last_of_pixel),
		.end_of_image (end_of_image)
	);

`ifndef SYNTHESIS
	a_fwd_needs_read: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_valid_q |-> s1_valid)
		else $error("forward register armed with no pixel waiting on the table");
	a_run_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		run_q < RUN_MAX)
		else $error("run count passed its limit");
	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && last_s1 |=> tbl_valid_q == '0 && run_q == '0 && prev_q == PREV_RESET)
		else $error("state not cleared after the last pixel");
`endif

endmodule
